// ----- hw/rtl/ctr_pkg.sv -----
// Shared types and constants for the colour temperature ramp.
// Used by ctr_ctrl, ctr_dpath and color_temperature_ramp; depends on nothing.
`default_nettype none

package ctr_pkg;

	// Field and datapath widths
	localparam int TEMP_W    = 16;
	localparam int FRAC_BITS = 16;
	localparam int ACC_W     = TEMP_W + FRAC_BITS;
	localparam int TIME_W    = 16;

	// Divider: one quotient bit per cycle over the whole magnitude
	localparam int DIV_STEPS = ACC_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Request kinds
	typedef enum logic {
		KIND_MOVE = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	// Controller states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // latch move operands, set up the divider
		logic step;    // one restoring division step
		logic commit;  // finish a move, load the result
		logic tick;    // apply a tick, load the result
	} ctr_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ctr_ctrl.sv -----
// Controller for the colour temperature ramp: state machine, divider step
// count and the result-valid flag. Depends on ctr_pkg.
`default_nettype none

module ctr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          kind,
	output logic               req_stall,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ctr_pkg::ctr_cmd_t  cmd
);
	import ctr_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               rsp_valid_q, rsp_valid_d;
	logic               out_free;
	logic               accept;

	// Result slot is free when empty or being taken this cycle
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) && out_free);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_TICK) begin
						cmd.tick = 1'b1;
					end else begin
						cmd.load = 1'b1;
						cnt_d    = CNT_W'(DIV_STEPS - 1);
						state_d  = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result valid flag
	always_comb begin
		rsp_valid_d = rsp_valid_q;
		if (cmd.tick || cmd.commit) begin
			rsp_valid_d = 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ctr_dpath.sv -----
// Datapath for the colour temperature ramp: ramp state, a bit-serial
// restoring divider and the result registers. Depends on ctr_pkg.
`default_nettype none

module ctr_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ctr_pkg::ctr_cmd_t             cmd,
	input  wire logic [ctr_pkg::TEMP_W-1:0]    target_temp,
	input  wire logic [ctr_pkg::TIME_W-1:0]    transition_time,
	output logic      [ctr_pkg::TEMP_W-1:0]    color_temp,
	output logic                               busy_res
);
	import ctr_pkg::*;

	// Ramp state
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   rate_q;     // low 32 bits of the signed step; the sum wraps
	logic [TIME_W-1:0]  ticks_q;
	logic [TEMP_W-1:0]  target_q;

	// Move in flight
	logic [TIME_W-1:0]  mv_time_q;
	logic [TIME_W-1:0]  divisor_q;
	logic               neg_q;
	logic [TEMP_W-1:0]  rem_q;
	logic [ACC_W-1:0]   quot_q;

	// Result registers
	logic [TEMP_W-1:0]  color_q;
	logic               busy_q;

	logic [ACC_W-1:0]   goal;
	logic               diff_neg;
	logic [ACC_W-1:0]   mag;
	logic [TEMP_W:0]    shifted;
	logic [TEMP_W:0]    trial;
	logic               q_bit;
	logic [ACC_W-1:0]   rate_new;
	logic               immediate;
	logic [TIME_W-1:0]  ticks_dec;
	logic [ACC_W-1:0]   acc_sum;
	logic [ACC_W-1:0]   mv_goal;

	// Move set-up: sign and magnitude of goal - accumulator
	assign goal     = {target_temp, {FRAC_BITS{1'b0}}};
	assign diff_neg = goal < acc_q;
	assign mag      = diff_neg ? (acc_q - goal) : (goal - acc_q);

	// One restoring division step
	assign shifted = {rem_q, quot_q[ACC_W-1]};
	assign trial   = shifted - {1'b0, divisor_q};
	assign q_bit   = !trial[TEMP_W];

	// Move completion: signed step, immediate jump when step is zero or time is zero or one
	assign rate_new  = neg_q ? (ACC_W'(0) - quot_q) : quot_q;
	assign immediate = (quot_q == '0) || (divisor_q == TIME_W'(1));
	assign mv_goal   = {target_q, {FRAC_BITS{1'b0}}};

	// Tick arithmetic
	assign ticks_dec = (ticks_q != '0) ? (ticks_q - 1'b1) : ticks_q;
	assign acc_sum   = acc_q + rate_q;

	// Ramp state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			rate_q   <= '0;
			ticks_q  <= '0;
			target_q <= '0;
		end else begin
			if (cmd.load) begin
				target_q <= target_temp;
			end
			if (cmd.commit) begin
				rate_q <= rate_new;
				if (immediate) begin
					acc_q   <= mv_goal;
					ticks_q <= '0;
				end else begin
					ticks_q <= mv_time_q;
				end
			end
			if (cmd.tick) begin
				ticks_q <= ticks_dec;
				if (ticks_dec != '0) begin
					acc_q <= acc_sum;
				end
			end
		end
	end

	// Divider registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mv_time_q <= transition_time;
			divisor_q <= (transition_time == '0) ? TIME_W'(1) : transition_time;
			neg_q     <= diff_neg;
			rem_q     <= '0;
			quot_q    <= mag;
		end else if (cmd.step) begin
			rem_q  <= q_bit ? trial[TEMP_W-1:0] : shifted[TEMP_W-1:0];
			quot_q <= {quot_q[ACC_W-2:0], q_bit};
		end
	end

	// Result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
			busy_q  <= 1'b0;
		end else if (cmd.commit) begin
			color_q <= immediate ? target_q : acc_q[ACC_W-1:FRAC_BITS];
			busy_q  <= !immediate && (mv_time_q != '0);
		end else if (cmd.tick) begin
			color_q <= (ticks_dec == '0) ? target_q : acc_sum[ACC_W-1:FRAC_BITS];
			busy_q  <= ticks_dec != '0;
		end
	end

	assign color_temp = color_q;
	assign busy_res   = busy_q;

endmodule

`default_nettype wire

// ----- hw/rtl/color_temperature_ramp.sv -----
// Top level of the colour temperature ramp: joins controller and datapath.
// Depends on ctr_pkg, ctr_ctrl and ctr_dpath.
//
//   channel   direction  handshake                 fields
//   request   in         req_valid / req_stall     kind, target_temp, transition_time
//   result    out        rsp_valid / rsp_stall     color_temp, busy_res
//
// A tick is applied when it is accepted: its result is in the output register the cycle after.
// A move runs through set-up, 32 divider steps (one quotient bit each) and commit.
// One request is in work at a time; the next is taken once the result register
// is empty or being taken. A stalled result holds and blocks the commit.
// Reset clears all ramp state to zero; no clearing pass.
`default_nettype none

module color_temperature_ramp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic                          kind,
	input  wire logic [ctr_pkg::TEMP_W-1:0]    target_temp,
	input  wire logic [ctr_pkg::TIME_W-1:0]    transition_time,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic      [ctr_pkg::TEMP_W-1:0]    color_temp,
	output logic                               busy_res
);
	import ctr_pkg::*;

	ctr_cmd_t cmd;

	ctr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.kind      (kind),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	ctr_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.target_temp     (target_temp),
		.transition_time (transition_time),
		.color_temp      (color_temp),
		.busy_res        (busy_res)
	);

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for color_temperature_ramp: directed and random move/tick requests.
// Depends on ctr_pkg and the color_temperature_ramp RTL; predicts every result internally.
`timescale 1ns / 100ps

module testbench;

	import ctr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TICKS = 40;

	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic              busy;
	} lamp_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	kind_t               kind;
	logic [TEMP_W-1:0]   target_temp;
	logic [TIME_W-1:0]   transition_time;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [TEMP_W-1:0]   color_temp;
	logic                busy_res;

	// Predicted ramp state
	logic [ACC_W-1:0]    ramp_acc;
	longint              ramp_step;
	logic [TIME_W-1:0]   ramp_ticks;
	logic [TEMP_W-1:0]   ramp_target;
	logic [TEMP_W-1:0]   ramp_shown;

	lamp_t               lamp_q[$];
	int                  send_idle_pct;
	int                  stall_pct;
	int                  sent_count;
	int                  move_count;
	int                  tick_count;
	int                  checked_count;
	int                  error_count;
	int                  cycle_count;

	color_temperature_ramp dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.kind            (kind),
		.target_temp     (target_temp),
		.transition_time (transition_time),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.color_temp      (color_temp),
		.busy_res        (busy_res)
	);

	// Clock starts low so that the first rising edge comes after time zero
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Ramp predictor: advances the state by one request, returns what the lamp shows
	function automatic lamp_t predict_lamp(input kind_t k, input logic [TEMP_W-1:0] tgt,
			input logic [TIME_W-1:0] tt);
		logic [ACC_W-1:0] goal;
		longint           diff;
		longint           divisor;
		lamp_t            res;
		if (k == KIND_MOVE) begin
			goal        = {tgt, {FRAC_BITS{1'b0}}};
			diff        = longint'(goal) - longint'(ramp_acc);
			divisor     = (tt == '0) ? 64'sd1 : longint'(tt);
			ramp_target = tgt;
			ramp_ticks  = tt;
			ramp_step   = diff / divisor;
			// zero step or a time of zero or one: jump straight to the target
			if (ramp_step == 0 || divisor == 1) begin
				ramp_acc   = goal;
				ramp_ticks = '0;
			end
			ramp_shown = ramp_acc[ACC_W-1:FRAC_BITS];
		end else begin
			if (ramp_ticks != '0)
				ramp_ticks = ramp_ticks - 1'b1;
			if (ramp_ticks == '0) begin
				ramp_shown = ramp_target;
			end else begin
				ramp_acc   = ramp_acc + ramp_step[ACC_W-1:0];
				ramp_shown = ramp_acc[ACC_W-1:FRAC_BITS];
			end
		end
		res.temp = ramp_shown;
		res.busy = (ramp_ticks != '0);
		return res;
	endfunction

	// Sends one request, with random idle cycles first; leaves valid high
	task automatic send_request(input kind_t k, input logic [TEMP_W-1:0] tgt,
			input logic [TIME_W-1:0] tt);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid       <= 1'b1;
		kind            <= k;
		target_temp     <= tgt;
		transition_time <= tt;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		lamp_q.push_back(predict_lamp(k, tgt, tt));
		sent_count++;
		if (k == KIND_MOVE)
			move_count++;
		else
			tick_count++;
	endtask

	task automatic send_tick();
		send_request(KIND_TICK, TEMP_W'($urandom), TIME_W'($urandom));
	endtask

	// Holds the sender off until every outstanding result has come back
	task automatic drain_results();
		req_valid <= 1'b0;
		while (lamp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Receiver stall
	always @(posedge clk)
		rsp_stall <= ($urandom_range(99, 0) < stall_pct);

	// Result checker
	always @(posedge clk) begin : check_results
		lamp_t exp_v;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (lamp_q.size() == 0) begin
				$display("%0t: unexpected result temp=%h busy=%b", $time, color_temp, busy_res);
				error_count++;
			end else begin
				exp_v = lamp_q.pop_front();
				checked_count++;
				if (color_temp !== exp_v.temp) begin
					$display("%0t: color_temp expected %h actual %h",
						$time, exp_v.temp, color_temp);
					error_count++;
				end
				if (busy_res !== exp_v.busy) begin
					$display("%0t: busy_res expected %b actual %b",
						$time, exp_v.busy, busy_res);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, lamp_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Ticks with nothing in flight, extreme ignored fields
	task automatic test_idle_tick();
		send_request(KIND_TICK, 16'h0000, 16'h0000);
		send_request(KIND_TICK, 16'hFFFF, 16'hFFFF);
	endtask

	// Time 0 and 1 both jump at once
	task automatic test_immediate_moves();
		send_request(KIND_MOVE, 16'hFFFF, 16'h0000);
		send_request(KIND_MOVE, 16'h0000, 16'h0001);
		send_request(KIND_MOVE, 16'h1234, 16'h0000);
		send_tick();
	endtask

	// Full-scale ramps both ways, with a tick past the end
	task automatic test_full_ramps();
		send_request(KIND_MOVE, 16'h0000, 16'h0000);
		send_request(KIND_MOVE, 16'hFFFF, 16'h0002);
		repeat (3) send_tick();
		send_request(KIND_MOVE, 16'h0000, 16'h0005);
		repeat (6) send_tick();
	endtask

	// Last tick leaves a fraction behind; a move back is then too small to step
	task automatic test_zero_step();
		send_request(KIND_MOVE, 16'h0001, 16'h0003);
		repeat (3) send_tick();
		send_request(KIND_MOVE, 16'h0000, 16'hFFFF);
		send_tick();
	endtask

	// Long ramp cut short by a new move
	task automatic test_interrupted_ramp();
		send_request(KIND_MOVE, 16'hFFFF, 16'hFFFF);
		repeat (3) send_tick();
		send_request(KIND_MOVE, 16'h8000, 16'h0007);
		repeat (4) send_tick();
	endtask

	// Random traffic: mostly a move followed by a run of ticks, some noise
	task automatic run_random_phase(input int idle_pct, input int stall_in, input int n_items);
		int               stop_at;
		int               sel;
		int               n_ticks;
		logic [TIME_W-1:0] tt;
		send_idle_pct = idle_pct;
		stall_pct     = stall_in;
		stop_at       = sent_count + n_items;
		while (sent_count < stop_at) begin
			sel = $urandom_range(9, 0);
			if (sel <= 6) begin
				case ($urandom_range(9, 0))
					0:       tt = TIME_W'($urandom_range(1, 0));
					1:       tt = TIME_W'($urandom);
					2:       tt = TIME_W'($urandom_range(200, 13));
					default: tt = TIME_W'($urandom_range(12, 2));
				endcase
				send_request(KIND_MOVE, TEMP_W'($urandom), tt);
				if ($urandom_range(3, 0) == 0)
					n_ticks = $urandom_range(int'(tt), 0);
				else
					n_ticks = int'(tt) + $urandom_range(2, 0);
				if (n_ticks > 30)
					n_ticks = 30;
				repeat (n_ticks) send_tick();
			end else if (sel <= 8) begin
				send_request(kind_t'($urandom_range(1, 0)), TEMP_W'($urandom), TIME_W'($urandom));
			end else begin
				send_request(KIND_MOVE, TEMP_W'($urandom), TIME_W'($urandom));
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n          <= 1'b0;
		req_valid       <= 1'b0;
		kind            <= KIND_MOVE;
		target_temp     <= '0;
		transition_time <= '0;
		rsp_stall       <= 1'b0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		sent_count      = 0;
		move_count      = 0;
		tick_count      = 0;
		checked_count   = 0;
		error_count     = 0;
		cycle_count     = 0;
		ramp_acc        = '0;
		ramp_step       = 0;
		ramp_ticks      = '0;
		ramp_target     = '0;
		ramp_shown      = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_tick();
		test_immediate_moves();
		test_full_ramps();
		test_zero_step();
		test_interrupted_ramp();
		drain_results();

		run_random_phase(0, 0, 200);
		run_random_phase(65, 0, 200);
		run_random_phase(0, 65, 200);
		run_random_phase(16, 16, 200);

		while (lamp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);

		$display("Sent %0d requests (%0d moves, %0d ticks), checked %0d results",
			sent_count, move_count, tick_count, checked_count);
		$display("Handshake phases: free flow, sender gaps, receiver stalls, both");
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", error_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
